[design/pbos_pkg.sv]
// Package for the protocol-buffer observation serializer.
// Holds the field widths, the field key table and the fixed64 position range.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pbos_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned CNT_W   = 3;

  localparam logic [POS_W-1:0]  LAST_POS  = 4'd9;
  localparam logic [POS_W-1:0]  FIX_FIRST = 4'd2;
  localparam logic [POS_W-1:0]  FIX_LAST  = 4'd8;
  localparam logic [BYTE_W-1:0] CAP_RESET = 8'd255;
  localparam logic [BYTE_W:0]   FIX_LEN   = 9'd8;

  // Key byte of each field: tag shifted left by three, wire type in the low bits.
  function automatic logic [BYTE_W-1:0] field_key(input logic [POS_W-1:0] pos);
    logic [BYTE_W-1:0] k;
    case (pos)
      4'd0:    k = 8'd8;
      4'd1:    k = 8'd16;
      4'd2:    k = 8'd25;
      4'd3:    k = 8'd33;
      4'd4:    k = 8'd41;
      4'd5:    k = 8'd49;
      4'd6:    k = 8'd57;
      4'd7:    k = 8'd65;
      4'd8:    k = 8'd73;
      4'd9:    k = 8'd80;
      default: k = 8'd8;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[design/protobuf_observation_serializer.sv]
// Top level of the protocol-buffer observation serializer.
// Uses pbos_pkg for widths, the key table and the fixed64 position range.
//
// channel  direction  handshake             payload
// in       to block   in_valid / in_stall   in_field_value
// out      from block out_valid / out_stall out_byte, out_byte_valid, out_overflow,
//                                           out_end_of_message, out_message_length
// cfg      to block   cfg_valid / cfg_ready cfg_capacity_limit
//
// A field is taken in the accept cycle, then the key byte goes out, then N payload bytes
// (8 for fixed64, 1 to 10 for a varint), one byte per cycle unless out_stall holds a
// pending byte, through the shared shifter and the capacity compare.
// in_stall is high from acceptance until the last byte is issued.
// out_stall holds the output register and the sequencer with it while a byte is pending.
// Reset is synchronous, active low; capacity returns to 255 and the message restarts.
`timescale 1ns / 1ps
`default_nettype none

module protobuf_observation_serializer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [pbos_pkg::VALUE_W-1:0] in_field_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [pbos_pkg::BYTE_W-1:0]      out_byte,
  output logic                             out_byte_valid,
  output logic                             out_overflow,
  output logic                             out_end_of_message,
  output logic [pbos_pkg::BYTE_W-1:0]      out_message_length,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [pbos_pkg::BYTE_W-1:0] cfg_capacity_limit
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_BODY
  } state_t;

  state_t                         state_r, state_nxt;
  logic [pbos_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [pbos_pkg::BYTE_W-1:0]    bw_r, bw_nxt;
  logic                           ovf_r, ovf_nxt;
  logic [pbos_pkg::BYTE_W-1:0]    cap_r;
  logic [pbos_pkg::VALUE_W-1:0]   val_r, val_nxt;
  logic [pbos_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [pbos_pkg::BYTE_W-1:0]    out_byte_r, out_byte_nxt;
  logic                           out_bv_r, out_bv_nxt;
  logic                           out_ovf_r, out_ovf_nxt;
  logic                           out_eom_r, out_eom_nxt;
  logic [pbos_pkg::BYTE_W-1:0]    out_len_r, out_len_nxt;

  logic [pbos_pkg::POS_W-1:0]     pos_eff;
  logic                           is_fixed;
  logic                           more;
  logic                           can_emit;
  logic [pbos_pkg::BYTE_W-1:0]    raw_byte;
  logic                           full;
  logic                           wr_ok;
  logic                           ovf_put;
  logic [pbos_pkg::BYTE_W-1:0]    bw_put;
  logic                           last;
  logic                           fix_short;

  assign cfg_ready          = 1'b1;
  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_byte_valid     = out_bv_r;
  assign out_overflow       = out_ovf_r;
  assign out_end_of_message = out_eom_r;
  assign out_message_length = out_len_r;

  always_comb begin
    pos_eff   = (pos_r > pbos_pkg::LAST_POS) ? '0 : pos_r;
    is_fixed  = (pos_eff >= pbos_pkg::FIX_FIRST) && (pos_eff <= pbos_pkg::FIX_LAST);
    more      = |val_r[pbos_pkg::VALUE_W-1:7];
    can_emit  = !out_valid_r || !out_stall;

    // Byte selection in front of the shared capacity compare
    if (state_r == ST_KEY) begin
      raw_byte = pbos_pkg::field_key(pos_eff);
    end else if (!is_fixed && more) begin
      raw_byte = {1'b1, val_r[6:0]};
    end else begin
      raw_byte = val_r[7:0];
    end

    full    = (bw_r >= cap_r);
    wr_ok   = !ovf_r && !full;
    ovf_put = ovf_r || full;
    bw_put  = bw_r + {{(pbos_pkg::BYTE_W-1){1'b0}}, wr_ok};
    last    = (state_r == ST_BODY) && (is_fixed ? (cnt_r == '1) : !more);
    fix_short = ({1'b0, bw_put} + pbos_pkg::FIX_LEN) > {1'b0, cap_r};

    state_nxt     = state_r;
    pos_nxt       = pos_r;
    bw_nxt        = bw_r;
    ovf_nxt       = ovf_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_ovf_nxt   = out_ovf_r;
    out_eom_nxt   = out_eom_r;
    out_len_nxt   = out_len_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          val_nxt   = in_field_value;
          cnt_nxt   = '0;
          state_nxt = ST_KEY;
        end
      end
      ST_KEY, ST_BODY: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = wr_ok ? raw_byte : '0;
          out_bv_nxt    = wr_ok;
          out_ovf_nxt   = ovf_put;
          out_eom_nxt   = 1'b0;
          out_len_nxt   = '0;
          bw_nxt        = bw_put;
          ovf_nxt       = ovf_put;
          if (state_r == ST_KEY) begin
            // Fixed64 space check sits after the key byte
            if (is_fixed && fix_short) begin
              ovf_nxt = 1'b1;
            end
            state_nxt = ST_BODY;
          end else begin
            val_nxt = is_fixed ? (val_r >> 8) : (val_r >> 7);
            cnt_nxt = cnt_r + 1'b1;
            if (last) begin
              state_nxt = ST_IDLE;
              if (pos_eff == pbos_pkg::LAST_POS) begin
                out_eom_nxt = 1'b1;
                out_len_nxt = ovf_put ? '0 : bw_put;
                pos_nxt     = '0;
                bw_nxt      = '0;
                ovf_nxt     = 1'b0;
              end else begin
                pos_nxt = pos_eff + 1'b1;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      bw_r        <= '0;
      ovf_r       <= 1'b0;
      cap_r       <= pbos_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      bw_r        <= bw_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity_limit;
      end
    end
    val_r      <= val_nxt;
    cnt_r      <= cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_bv_r   <= out_bv_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_eom_r  <= out_eom_nxt;
    out_len_r  <= out_len_nxt;
  end

endmodule

`default_nettype wire

[design/pbos_checker.sv]
// Port-level checker for the protocol-buffer observation serializer, with its bind.
// Uses pbos_pkg for the port widths.
`timescale 1ns / 1ps
`default_nettype none

module pbos_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [pbos_pkg::BYTE_W-1:0] out_byte,
  input wire logic                        out_byte_valid,
  input wire logic                        out_overflow,
  input wire logic                        out_end_of_message,
  input wire logic [pbos_pkg::BYTE_W-1:0] out_message_length
);

  // A stalled request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_end_of_message))
    else $error("stalled output request changed");

  // Busy after taking a field
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a field is still in work");

  a_placeholder: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == '0)
    else $error("suppressed byte is not zero");

  a_len_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_message && out_overflow |-> out_message_length == '0)
    else $error("length reported after overflow");

  a_len_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_of_message |-> out_message_length == '0)
    else $error("length shown before message end");

endmodule

bind protobuf_observation_serializer pbos_checker u_pbos_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_byte           (out_byte),
  .out_byte_valid     (out_byte_valid),
  .out_overflow       (out_overflow),
  .out_end_of_message (out_end_of_message),
  .out_message_length (out_message_length)
);

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for protobuf_observation_serializer: encodes each field request
// in a local model and compares every emitted byte; capacity is rewritten between fields.
// Depends on pbos_pkg and the serializer RTL only.
`timescale 1ns / 1ps

module tb_top;
  import pbos_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES  = 3;
  localparam int unsigned DRAIN_CYCLES   = 24;
  localparam int unsigned TAIL_REQUESTS  = 40;
  localparam int unsigned RANDOM_MSGS    = 30;

  // Key byte per field position, position 0 in the low byte
  localparam logic [9:0][BYTE_W-1:0] FIELD_KEYS = {
    8'd80, 8'd73, 8'd65, 8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd16, 8'd8
  };

  typedef struct packed {
    logic               is_cfg;
    logic [VALUE_W-1:0] data;
  } request_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              written;
    logic              ovf;
    logic              eom;
    logic [BYTE_W-1:0] length;
  } enc_byte_t;

  logic                clk = 1'b1;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [VALUE_W-1:0]  in_field_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_byte_valid;
  logic                out_overflow;
  logic                out_end_of_message;
  logic [BYTE_W-1:0]   out_message_length;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [BYTE_W-1:0]   cfg_capacity_limit = CAP_RESET;

  request_t    request_q[$];
  enc_byte_t   encoded_byte_q[$];

  // Local copy of the serializer state
  logic [BYTE_W-1:0]   cap_limit;
  logic [POS_W-1:0]    msg_pos;
  logic [BYTE_W-1:0]   msg_bytes;
  logic                msg_overflow;

  int unsigned mismatch_cnt = 0;
  logic        tail_phase = 1'b0;

  protobuf_observation_serializer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_field_value     (in_field_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_overflow       (out_overflow),
    .out_end_of_message (out_end_of_message),
    .out_message_length (out_message_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_capacity_limit (cfg_capacity_limit)
  );

  always begin
    #10 clk = 1'b0;
    #10 clk = 1'b1;
  end

  task automatic emit_byte(input logic [BYTE_W-1:0] b);
    enc_byte_t r;
    r = '0;
    if (!msg_overflow) begin
      if (msg_bytes >= cap_limit) begin
        msg_overflow = 1'b1;
      end else begin
        r.written = 1'b1;
        msg_bytes = msg_bytes + 8'd1;
      end
    end
    r.data = r.written ? b : '0;
    r.ovf  = msg_overflow;
    encoded_byte_q.push_back(r);
  endtask

  task automatic encode_field(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] v;
    logic [POS_W-1:0]   pos;
    enc_byte_t          last;
    v = value;
    pos = (msg_pos > LAST_POS) ? '0 : msg_pos;
    emit_byte(FIELD_KEYS[pos]);
    if (pos >= FIX_FIRST && pos <= FIX_LAST) begin
      // the whole fixed64 word must fit once the key is out
      if (!msg_overflow && ({1'b0, msg_bytes} + FIX_LEN > {1'b0, cap_limit}))
        msg_overflow = 1'b1;
      for (int i = 0; i < 8; i++) emit_byte(v[8*i +: 8]);
    end else begin
      while (v >= 64'h80) begin
        emit_byte({1'b1, v[6:0]});
        v = v >> 7;
      end
      emit_byte(v[7:0]);
    end
    if (pos == LAST_POS) begin
      last = encoded_byte_q.pop_back();
      last.eom = 1'b1;
      last.length = msg_overflow ? '0 : msg_bytes;
      encoded_byte_q.push_back(last);
      msg_pos = '0;
      msg_bytes = '0;
      msg_overflow = 1'b0;
    end else begin
      msg_pos = pos + 4'd1;
    end
  endtask

  task automatic push_field(input logic [VALUE_W-1:0] v);
    request_q.push_back('{is_cfg: 1'b0, data: v});
  endtask

  task automatic push_cfg(input logic [BYTE_W-1:0] cap);
    request_q.push_back('{is_cfg: 1'b1, data: {{(VALUE_W-BYTE_W){1'b0}}, cap}});
  endtask

  function automatic logic [BYTE_W-1:0] pick_capacity();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      2:       return 8'($urandom_range(0, 255));
      3:       return 8'($urandom_range(60, 100));
      default: return CAP_RESET;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] rand_field_value();
    logic [VALUE_W-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return r;
      // land on either side of a varint length step
      4:       return (64'd1 << (7 * $urandom_range(0, 9))) - 64'($urandom_range(0, 1));
      default: return r >> $urandom_range(0, 63);
    endcase
  endfunction

  // Request driver
  always @(posedge clk) begin : drv
    logic               nxt_valid;
    logic               nxt_cfg_valid;
    logic [VALUE_W-1:0] nxt_value;
    logic [BYTE_W-1:0]  nxt_cap;
    request_t           req;
    int unsigned        gap_cnt;
    int unsigned        gap_pct;
    int unsigned        idle_run;
    int unsigned        fields_sent;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      gap_cnt = 0;
      gap_pct = 25;
      idle_run = 0;
      fields_sent = 0;
      cap_limit = CAP_RESET;
      msg_pos = '0;
      msg_bytes = '0;
      msg_overflow = 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_cfg_valid = cfg_valid;
      nxt_value = in_field_value;
      nxt_cap = cfg_capacity_limit;
      if (in_valid && !in_stall) begin
        encode_field(in_field_value);
        nxt_valid = 1'b0;
        fields_sent++;
        if (fields_sent % 32 == 0) gap_pct = 25 * $urandom_range(0, 2);
        if (!tail_phase && $urandom_range(0, 99) < gap_pct) gap_cnt = $urandom_range(1, 9);
      end
      if (cfg_valid && cfg_ready) begin
        cap_limit = cfg_capacity_limit;
        nxt_cfg_valid = 1'b0;
      end
      // a capacity write waits until every pending byte has drained
      if (encoded_byte_q.size() == 0 && !nxt_valid) idle_run++;
      else idle_run = 0;
      if (!nxt_valid && !nxt_cfg_valid && request_q.size() > 0) begin
        if (request_q[0].is_cfg) begin
          if (idle_run >= SETTLE_CYCLES) begin
            req = request_q.pop_front();
            nxt_cfg_valid = 1'b1;
            nxt_cap = req.data[BYTE_W-1:0];
          end
        end else if (gap_cnt > 0) begin
          gap_cnt--;
        end else begin
          req = request_q.pop_front();
          nxt_valid = 1'b1;
          nxt_value = req.data;
        end
      end
      tail_phase <= (request_q.size() < TAIL_REQUESTS);
      in_valid <= nxt_valid;
      in_field_value <= nxt_value;
      cfg_valid <= nxt_cfg_valid;
      cfg_capacity_limit <= nxt_cap;
    end
  end

  // Byte monitor and back-pressure
  always @(posedge clk) begin : mon
    enc_byte_t   exp_r;
    int unsigned stall_cnt;
    int unsigned stall_pct;
    int unsigned seen;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_cnt = 0;
      stall_pct = 15;
      seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen++;
        if (seen % 64 == 0) stall_pct = 20 * $urandom_range(0, 2);
        if (encoded_byte_q.size() == 0) begin
          $error("unexpected byte: out_byte %0h", out_byte);
          mismatch_cnt++;
        end else begin
          exp_r = encoded_byte_q.pop_front();
          if (out_byte !== exp_r.data) begin
            $error("out_byte: expected %0h, actual %0h", exp_r.data, out_byte);
            mismatch_cnt++;
          end
          if (out_byte_valid !== exp_r.written) begin
            $error("out_byte_valid: expected %0b, actual %0b", exp_r.written, out_byte_valid);
            mismatch_cnt++;
          end
          if (out_overflow !== exp_r.ovf) begin
            $error("out_overflow: expected %0b, actual %0b", exp_r.ovf, out_overflow);
            mismatch_cnt++;
          end
          if (out_end_of_message !== exp_r.eom) begin
            $error("out_end_of_message: expected %0b, actual %0b", exp_r.eom,
                   out_end_of_message);
            mismatch_cnt++;
          end
          if (out_message_length !== exp_r.length) begin
            $error("out_message_length: expected %0d, actual %0d", exp_r.length,
                   out_message_length);
            mismatch_cnt++;
          end
        end
      end
      if (stall_cnt > 0) stall_cnt--;
      else if (!tail_phase && $urandom_range(0, 99) < stall_pct)
        stall_cnt = $urandom_range(1, 9);
      out_stall <= (stall_cnt > 0);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (!rst_n) begin
      quiet = 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("protobuf_observation_serializer regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int cut;
    // fixed64 word refused after its key; the last varint is all placeholders
    push_cfg(8'd70);
    push_field('0);
    push_field('1);
    push_field('0);
    push_field('1);
    push_field(64'h3FF0_0000_0000_0000);
    push_field(64'h8000_0000_0000_0000);
    push_field(64'h7FF0_0000_0000_0000);
    push_field(64'h0123_4567_89AB_CDEF);
    push_field(64'hFEDC_BA98_7654_3210);
    push_field(64'h7F);
    // zero capacity, then a larger one mid-message: nothing more is written
    push_cfg(8'd0);
    push_field(64'h80);
    push_field(64'h3FFF);
    push_field(64'h4000);
    push_field(64'h5555_5555_5555_5555);
    push_field(64'hAAAA_AAAA_AAAA_AAAA);
    push_cfg(8'd200);
    push_field(64'h1);
    push_field(64'hFF);
    push_field(64'hFFFF_FFFF);
    push_field(64'hFFFF_FFFF_0000_0000);
    push_field(64'h8000_0000_0000_0000);
    // varint cut part-way through its payload
    push_cfg(8'd5);
    push_field('0);
    push_field('1);
    for (int f = 2; f < 10; f++) push_field(64'h1234_5678 << f);
    push_cfg(CAP_RESET);
    for (int m = 0; m < RANDOM_MSGS; m++) begin
      if ($urandom_range(0, 1)) push_cfg(pick_capacity());
      cut = $urandom_range(1, 30);
      for (int f = 0; f < 10; f++) begin
        if (f == cut) push_cfg(pick_capacity());
        push_field(rand_field_value());
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_valid || cfg_valid) @(posedge clk);
    while (encoded_byte_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("protobuf_observation_serializer regression: pass");
    else
      $display("protobuf_observation_serializer regression: fail");
    $finish;
  end

endmodule

[protobuf_observation_serializer.f]
design/pbos_pkg.sv
design/protobuf_observation_serializer.sv
design/pbos_checker.sv
verif/tb_top.sv
